// ----- sv/clpg_pkg.sv -----
// ----------------------------------------------------------------------------
// clpg_pkg
// Shared types and constants for the clamped line pixel generator.
// ----------------------------------------------------------------------------
package clpg_pkg;

  localparam int MAX_SIDE        = 64;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);

  localparam int COORD_W    = 6;
  localparam int SIZE_W     = 7;
  localparam int PITCH_W    = 15;
  localparam int ADDR_W     = 20;
  localparam int COLOR_W    = 32;
  localparam int IN_COORD_W = 16;
  localparam int ERR_W      = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 64;

  // Step direction codes.
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_PLUS  = 2'd1;
  localparam logic [1:0] DIR_MINUS = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_PITCH  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_BODY,
    ST_END
  } state_t;

  typedef struct packed {
    logic load;
    logic emit_start;
    logic emit_body;
    logic emit_end;
  } clpg_cmd_t;

  typedef struct packed {
    logic init_zero;
    logic steps_one;
  } clpg_status_t;

endpackage

// ----- sv/clamped_line_pixel_generator_core.sv -----
// ----------------------------------------------------------------------------
// clamped_line_pixel_generator_core
// Clamps line endpoints into the surface and emits one pixel write per cycle
// along the line, unless out_tready stalls, with an error-accumulator stepper.
//
//   Channel  Dir  Handshake              Carries
//   in_      in   in_tvalid/in_tready    one line request
//   out_     out  out_tvalid/out_tready  one pixel write, tlast on the end pixel
//   cfg_     in   cfg_we                 surface width, height, row pitch
//
// A line of major length M gives max(M+1, 2) pixel writes, one per cycle from
// the output register unless stalled; the step sequencer takes the next line
// request only once it is back in idle after the end pixel.
// A stall on out_tready holds the sequencer; no pixel is dropped.
// Reset is synchronous and active low; it restores the default configuration.
// ----------------------------------------------------------------------------
module clamped_line_pixel_generator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [clpg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [clpg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // from_x[15:0], from_y[31:16], to_x[47:32], to_y[63:48], color_word[95:64]
  input  logic [clpg_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pixel_x[5:0], pixel_y[11:6], pixel_address[31:12], pixel_color[63:32]
  output logic [clpg_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast
);
  import clpg_pkg::*;

  clpg_cmd_t          cmd;
  clpg_status_t       status;
  logic [COORD_W-1:0] pixel_x, pixel_y;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;

  clpg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  clpg_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .from_x        (in_tdata[15:0]),
    .from_y        (in_tdata[31:16]),
    .to_x          (in_tdata[47:32]),
    .to_y          (in_tdata[63:48]),
    .color_word    (in_tdata[95:64]),
    .cmd           (cmd),
    .status        (status),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (out_tlast)
  );

  assign out_tdata = {pixel_color, pixel_address, pixel_y, pixel_x};

endmodule

// ----- sv/clpg_ctrl.sv -----
// ----------------------------------------------------------------------------
// clpg_ctrl
// Sequencer for one line: start pixel, body steps, end pixel, and the valid
// flag of the output register.
// ----------------------------------------------------------------------------
module clpg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  clpg_pkg::clpg_status_t status,
  output clpg_pkg::clpg_cmd_t    cmd
);
  import clpg_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;

  // The output register can take a new item when empty or being drained.
  assign slot_free = !out_valid_r || out_tready;
  assign accept    = in_tvalid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_START;
      ST_START: if (slot_free) state_nxt = status.init_zero ? ST_END : ST_BODY;
      ST_BODY:  if (slot_free && status.steps_one) state_nxt = ST_END;
      ST_END:   if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_tready     = 1'b0;
    cmd.load      = accept;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_START: cmd.emit_start = slot_free;
      ST_BODY:  cmd.emit_body = slot_free;
      ST_END:   cmd.emit_end = slot_free;
      default:  in_tready = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_start || cmd.emit_body || cmd.emit_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_START)
    else $error("accepted line did not enter the start phase");

  a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_start || cmd.emit_body || cmd.emit_end) |=> out_valid_r)
    else $error("emitted pixel did not appear at the output");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && !slot_free) |=> $stable(state_r))
    else $error("sequencer advanced while the output was stalled");

endmodule

// ----- sv/clpg_datapath.sv -----
// ----------------------------------------------------------------------------
// clpg_datapath
// Configuration registers, endpoint clamping, error-accumulator stepper and
// the output register with its address computation.
// ----------------------------------------------------------------------------
module clpg_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [clpg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [clpg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [clpg_pkg::IN_COORD_W-1:0]      from_x,
  input  logic [clpg_pkg::IN_COORD_W-1:0]      from_y,
  input  logic [clpg_pkg::IN_COORD_W-1:0]      to_x,
  input  logic [clpg_pkg::IN_COORD_W-1:0]      to_y,
  input  logic [clpg_pkg::COLOR_W-1:0]         color_word,
  input  clpg_pkg::clpg_cmd_t                  cmd,
  output clpg_pkg::clpg_status_t               status,
  output logic [clpg_pkg::COORD_W-1:0]         pixel_x,
  output logic [clpg_pkg::COORD_W-1:0]         pixel_y,
  output logic [clpg_pkg::ADDR_W-1:0]          pixel_address,
  output logic [clpg_pkg::COLOR_W-1:0]         pixel_color,
  output logic                                 last_pixel
);
  import clpg_pkg::*;

  localparam int PROD_W = COORD_W + PITCH_W;

  function automatic logic [COORD_W-1:0] eff_max(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] m;
    if (s == '0) begin
      m = '0;
    end else if (s > SIZE_W'(MAX_SIDE)) begin
      m = SIZE_W'(MAX_SIDE - 1);
    end else begin
      m = s - SIZE_W'(1);
    end
    return m[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] clamp(input logic [IN_COORD_W-1:0] c,
                                                input logic [COORD_W-1:0] mx);
    logic [COORD_W-1:0] r;
    if (c[IN_COORD_W-1]) begin
      r = '0;
    end else if (c > {{(IN_COORD_W-COORD_W){1'b0}}, mx}) begin
      r = mx;
    end else begin
      r = c[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] step_dir(input logic [COORD_W-1:0] f,
                                          input logic [COORD_W-1:0] t);
    logic [1:0] d;
    if (t > f) begin
      d = DIR_PLUS;
    end else if (t < f) begin
      d = DIR_MINUS;
    end else begin
      d = DIR_NONE;
    end
    return d;
  endfunction

  function automatic logic [COORD_W-1:0] apply_dir(input logic [COORD_W-1:0] v,
                                                   input logic [1:0] d);
    logic [COORD_W-1:0] r;
    case (d)
      DIR_PLUS:  r = v + COORD_W'(1);
      DIR_MINUS: r = v - COORD_W'(1);
      default:   r = v;
    endcase
    return r;
  endfunction

  logic [SIZE_W-1:0]  width_r, height_r;
  logic [PITCH_W-1:0] pitch_r;

  logic [COORD_W-1:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic [COLOR_W-1:0] color_r;
  logic [1:0]         dir_x_r, dir_y_r;
  logic               major_x_r;
  logic [COORD_W-1:0] major_r, minor_r, steps_r;
  logic [ERR_W-1:0]   err_r;

  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;

  logic [COORD_W-1:0] max_x, max_y;
  logic [COORD_W-1:0] adx, ady, major_c, minor_c;
  logic               major_x_c;
  logic [ERR_W-1:0]   err_sum, err_nxt;
  logic               err_ge;
  logic [COORD_W-1:0] step_x, step_y;
  logic [PROD_W-1:0]  row_offset;

  assign max_x = eff_max(width_r);
  assign max_y = eff_max(height_r);

  // Line geometry from the clamped endpoints, latched on the start pixel.
  assign adx       = (tgt_x_r >= cur_x_r) ? tgt_x_r - cur_x_r : cur_x_r - tgt_x_r;
  assign ady       = (tgt_y_r >= cur_y_r) ? tgt_y_r - cur_y_r : cur_y_r - tgt_y_r;
  assign major_x_c = adx > ady;
  assign major_c   = major_x_c ? adx : ady;
  assign minor_c   = major_x_c ? ady : adx;

  assign status.init_zero = major_c <= COORD_W'(1);
  assign status.steps_one = steps_r == COORD_W'(1);

  // One body step: always move on the major axis, on the minor axis when the
  // accumulated error reaches the major length.
  assign err_sum = err_r + ERR_W'(minor_r);
  assign err_ge  = err_sum >= ERR_W'(major_r);
  assign err_nxt = err_ge ? err_sum - ERR_W'(major_r) : err_sum;

  always_comb begin
    if (major_x_r) begin
      step_x = apply_dir(cur_x_r, dir_x_r);
      step_y = err_ge ? apply_dir(cur_y_r, dir_y_r) : cur_y_r;
    end else begin
      step_y = apply_dir(cur_y_r, dir_y_r);
      step_x = err_ge ? apply_dir(cur_x_r, dir_x_r) : cur_x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(MAX_SIDE);
      height_r <= SIZE_W'(MAX_SIDE);
      pitch_r  <= PITCH_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[SIZE_W-1:0];
        CFG_PITCH:  pitch_r  <= cfg_wdata[PITCH_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
      err_r   <= '0;
    end else if (cmd.emit_start) begin
      steps_r <= (major_c != '0) ? major_c - COORD_W'(1) : '0;
      err_r   <= '0;
    end else if (cmd.emit_body) begin
      steps_r <= steps_r - COORD_W'(1);
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r <= clamp(from_x, max_x);
      cur_y_r <= clamp(from_y, max_y);
      tgt_x_r <= clamp(to_x, max_x);
      tgt_y_r <= clamp(to_y, max_y);
      color_r <= color_word;
    end
    if (cmd.emit_start) begin
      dir_x_r     <= step_dir(cur_x_r, tgt_x_r);
      dir_y_r     <= step_dir(cur_y_r, tgt_y_r);
      major_x_r   <= major_x_c;
      major_r     <= major_c;
      minor_r     <= minor_c;
      out_x_r     <= cur_x_r;
      out_y_r     <= cur_y_r;
      out_color_r <= color_r;
      out_last_r  <= 1'b0;
    end
    if (cmd.emit_body) begin
      cur_x_r     <= step_x;
      cur_y_r     <= step_y;
      out_x_r     <= step_x;
      out_y_r     <= step_y;
      out_color_r <= color_r;
      out_last_r  <= 1'b0;
    end
    if (cmd.emit_end) begin
      out_x_r     <= tgt_x_r;
      out_y_r     <= tgt_y_r;
      out_color_r <= color_r;
      out_last_r  <= 1'b1;
    end
  end

  // Address from the registered pixel; the row offset wraps at the address width.
  assign row_offset    = PROD_W'(out_y_r) * PROD_W'(pitch_r);
  assign pixel_address = row_offset[ADDR_W-1:0]
                       + (ADDR_W'(out_x_r) << BPP_SHIFT);
  assign pixel_x       = out_x_r;
  assign pixel_y       = out_y_r;
  assign pixel_color   = out_color_r;
  assign last_pixel    = out_last_r;

  a_err_below_major: assert property (@(posedge clk) disable iff (!rst_n)
    (steps_r != '0) |-> (err_r < ERR_W'(major_r)))
    else $error("error accumulator reached the major length");

  a_minor_le_major: assert property (@(posedge clk) disable iff (!rst_n)
    (steps_r != '0) |-> (minor_r <= major_r))
    else $error("minor length exceeds major length during the body");

  a_start_clears_err: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_start |=> (err_r == '0))
    else $error("error accumulator not cleared at line start");

endmodule
